### sv/tci_pkg.sv
// Shared types and constants for the tabulated curve interpolator.
// Depends on nothing; the top level, table, divider and testbench import it.
package tci_pkg;

   localparam logic [16:0] ONE_Q15 = 17'd32768;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_CMP,
      ST_RD0,
      ST_RD1,
      ST_LOAD,
      ST_DIFF,
      ST_DEN,
      ST_MUL,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_WET_VAL,
      OP_NONWET_VAL,
      OP_PRESS_VAL,
      OP_WET_SLOPE,
      OP_NONWET_SLOPE,
      OP_PRESS_SLOPE
   } op_type;

   typedef enum logic [2:0] {
      CSR_TABLE_LENGTH,
      CSR_RESIDUAL_WATER,
      CSR_RESIDUAL_OIL,
      CSR_MAX_PRESSURE,
      CSR_MAX_SLOPE
   } csr_idx_type;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [15:0] sat;
      logic [15:0] wet;
      logic [15:0] nonwet;
      logic [31:0] press;
   } entry_type;

   localparam logic signed [65:0] PERM_MIN = -66'sd32768;
   localparam logic signed [65:0] PERM_MAX = 66'sd65535;
   localparam logic signed [65:0] PC_MIN   = -66'sd2147483648;
   localparam logic signed [65:0] PC_MAX   = 66'sd4294967295;
   localparam logic signed [65:0] S32_MIN  = -66'sd2147483648;
   localparam logic signed [65:0] S32_MAX  = 66'sd2147483647;
   localparam logic signed [65:0] S48_MIN  = -66'sd140737488355328;
   localparam logic signed [65:0] S48_MAX  = 66'sd140737488355327;

   function automatic logic signed [65:0] sat66(input logic signed [65:0] v,
                                                input logic signed [65:0] lo,
                                                input logic signed [65:0] hi);
      if (v < lo) begin
         return lo;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

endpackage

### sv/tabulated_curve_interpolator.sv
// Top level of the tabulated curve interpolator: CSRs, sequencer, shared multiplier.
// Depends on tci_pkg, tci_table and tci_div.
//
//   Channel | Direction | Handshake             | Moves
//   req     | in        | req_valid / req_ready | table write or query item
//   rsp     | out       | rsp_valid / rsp_ready | one result item per query
//   csr     | in/out    | APB psel/penable      | five configuration registers
//
// A write item produces no result. A query item visits k breakpoints in its search,
// where k is 1 to L-1, and then makes six divider passes, one per result value.
// req_ready is high only while the sequencer is idle, so the next item is accepted
// in the next cycle at the earliest. A finished result waits in the output register;
// the next query may run meanwhile and holds its own result until that register is
// free. Reset is synchronous and restores the CSRs, the sequencer state and the
// output valid flag.
module tabulated_curve_interpolator #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [4:0]         req_entry_index,
   input  logic [15:0]        req_sat_point,
   input  logic [15:0]        req_wet_perm_value,
   input  logic [15:0]        req_nonwet_perm_value,
   input  logic [31:0]        req_pressure_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_wet_perm,
   output logic signed [16:0] rsp_nonwet_perm,
   output logic signed [32:0] rsp_cap_pressure,
   output logic signed [31:0] rsp_wet_perm_slope,
   output logic signed [31:0] rsp_nonwet_perm_slope,
   output logic signed [47:0] rsp_pressure_slope,
   output logic               rsp_bad_residuals,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import tci_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // Configuration registers.
   logic [5:0]  table_length_ff;
   logic [14:0] residual_water_ff;
   logic [14:0] residual_oil_ff;
   logic [31:0] max_pressure_ff;
   logic [31:0] max_slope_ff;
   logic        csr_wr;
   csr_idx_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_idx_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff   <= 6'd2;
         residual_water_ff <= '0;
         residual_oil_ff   <= '0;
         max_pressure_ff   <= 32'd2560000000;
         max_slope_ff      <= 32'd25600000;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_TABLE_LENGTH:   table_length_ff   <= pwdata[5:0];
            CSR_RESIDUAL_WATER: residual_water_ff <= pwdata[14:0];
            CSR_RESIDUAL_OIL:   residual_oil_ff   <= pwdata[14:0];
            CSR_MAX_PRESSURE:   max_pressure_ff   <= pwdata;
            CSR_MAX_SLOPE:      max_slope_ff      <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_TABLE_LENGTH:   prdata = {26'd0, table_length_ff};
         CSR_RESIDUAL_WATER: prdata = {17'd0, residual_water_ff};
         CSR_RESIDUAL_OIL:   prdata = {17'd0, residual_oil_ff};
         CSR_MAX_PRESSURE:   prdata = max_pressure_ff;
         CSR_MAX_SLOPE:      prdata = max_slope_ff;
         default:            prdata = '0;
      endcase
   end

   // The residual span 1 - swr - snr; zero or negative flags bad residuals.
   logic signed [16:0] span;
   logic               bad;
   assign span = $signed(ONE_Q15 - {2'b0, residual_water_ff} - {2'b0, residual_oil_ff});
   assign bad  = span[16] || (span == 17'sd0);

   // The active length is clamped into [2, TABLE_DEPTH]; last holds L-1.
   logic [IDX_W-1:0] last_idx;
   always_comb begin
      int len;
      len = int'(table_length_ff);
      if (len < 2) begin
         len = 2;
      end
      if (len > TABLE_DEPTH) begin
         len = TABLE_DEPTH;
      end
      last_idx = IDX_W'(len - 1);
   end

   // Table storage.
   entry_type        wr_data;
   entry_type        rd_data;
   logic [IDX_W-1:0] rd_addr;
   logic             tbl_wr;

   assign wr_data = '{sat: req_sat_point, wet: req_wet_perm_value,
                      nonwet: req_nonwet_perm_value, press: req_pressure_value};
   assign tbl_wr  = req_valid && req_ready && (req_type == REQ_WRITE);

   tci_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock    (clock),
      .wr_en    (tbl_wr),
      .wr_index (req_entry_index),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   // Sequencer state and working registers.
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   seg_ff;
   logic [15:0]        s_ff;
   entry_type          e0_ff, e1_ff;
   logic signed [16:0] ds_ff, ss_ff, dvw_ff, dvn_ff;
   logic signed [32:0] dvp_ff;
   logic signed [33:0] den_ff;
   logic signed [49:0] prod_ff;
   op_type             op_ff;
   logic signed [47:0] res_ff [6];
   logic               rsp_valid_ff;
   logic               hit;

   assign hit = rd_data.sat > s_ff;

   // Shared multiplier: the span product first, then one product per value.
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] mul_p;
   always_comb begin
      mul_a = {{16{ds_ff[16]}}, ds_ff};
      mul_b = span;
      if (state_ff == ST_MUL) begin
         mul_b = ss_ff;
         case (op_ff)
            OP_WET_VAL:    mul_a = {{16{dvw_ff[16]}}, dvw_ff};
            OP_NONWET_VAL: mul_a = {{16{dvn_ff[16]}}, dvn_ff};
            default:       mul_a = dvp_ff;
         endcase
      end
   end
   assign mul_p = mul_a * mul_b;

   // Divider operands: value steps divide the product by the segment width,
   // slope steps divide the shifted difference by width times span.
   logic               div_start;
   logic signed [63:0] div_numer;
   logic signed [33:0] div_denom;
   logic               div_done;
   logic signed [64:0] div_quot;

   assign div_start = (state_ff == ST_DIVGO);

   always_comb begin
      div_denom = den_ff;
      case (op_ff)
         OP_WET_VAL, OP_NONWET_VAL, OP_PRESS_VAL: begin
            div_numer = {{14{prod_ff[49]}}, prod_ff};
            div_denom = {{17{ds_ff[16]}}, ds_ff};
         end
         OP_WET_SLOPE:    div_numer = {{16{dvw_ff[16]}}, dvw_ff, 31'd0};
         OP_NONWET_SLOPE: div_numer = {{16{dvn_ff[16]}}, dvn_ff, 31'd0};
         default:         div_numer = {dvp_ff[32], dvp_ff, 30'd0};
      endcase
   end

   tci_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Post-processing of one quotient: add the base value and clamp for a value
   // step; for a slope step handle flat segments and bad residuals, then clamp.
   logic signed [65:0] post;
   always_comb begin
      logic signed [65:0] q;
      logic signed [65:0] v0;
      logic signed [65:0] lo, hi;
      logic               dv_zero, dv_neg;
      q  = (ds_ff == 17'sd0) ? 66'sd0 : {div_quot[64], div_quot};
      v0 = '0;
      lo = S32_MIN;
      hi = S32_MAX;
      dv_zero = 1'b0;
      dv_neg  = 1'b0;
      case (op_ff)
         OP_WET_VAL: begin
            v0 = $signed({50'd0, e0_ff.wet});
            lo = PERM_MIN;
            hi = PERM_MAX;
         end
         OP_NONWET_VAL: begin
            v0 = $signed({50'd0, e0_ff.nonwet});
            lo = PERM_MIN;
            hi = PERM_MAX;
         end
         OP_PRESS_VAL: begin
            v0 = $signed({34'd0, e0_ff.press});
            lo = PC_MIN;
            hi = PC_MAX;
         end
         OP_WET_SLOPE: begin
            dv_zero = (dvw_ff == 17'sd0);
            dv_neg  = dvw_ff[16];
         end
         OP_NONWET_SLOPE: begin
            dv_zero = (dvn_ff == 17'sd0);
            dv_neg  = dvn_ff[16];
         end
         default: begin
            dv_zero = (dvp_ff == 33'sd0);
            dv_neg  = dvp_ff[32];
            lo = S48_MIN;
            hi = S48_MAX;
         end
      endcase
      if (op_ff == OP_WET_VAL || op_ff == OP_NONWET_VAL || op_ff == OP_PRESS_VAL) begin
         post = sat66(v0 + q, lo, hi);
      end else if (ds_ff == 17'sd0 || dv_zero) begin
         post = '0;
      end else if (bad) begin
         post = (dv_neg != ds_ff[16]) ? lo : hi;
      end else begin
         post = sat66({div_quot[64], div_quot}, lo, hi);
      end
   end

   // Next state and read address.
   always_comb begin
      state_in = state_ff;
      rd_addr  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_type == REQ_QUERY)) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: state_in = ST_CMP;
         ST_CMP: begin
            if (hit || (idx_ff == last_idx)) begin
               state_in = ST_RD0;
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_RD0: begin
            rd_addr  = seg_ff - IDX_W'(1);
            state_in = ST_RD1;
         end
         ST_RD1: begin
            rd_addr  = seg_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_DEN;
         ST_DEN:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_DIVGO;
         ST_DIVGO: state_in = ST_DIVWAIT;
         ST_DIVWAIT: begin
            if (div_done) begin
               state_in = (op_ff == OP_PRESS_SLOPE) ? ST_FINISH : ST_MUL;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            s_ff   <= req_sat_point;
            idx_ff <= IDX_W'(1);
         end
         ST_CMP: begin
            if (hit) begin
               seg_ff <= idx_ff;
            end else if (idx_ff == last_idx) begin
               seg_ff <= last_idx;
            end else begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         ST_RD1:  e0_ff <= rd_data;
         ST_LOAD: e1_ff <= rd_data;
         ST_DIFF: begin
            ds_ff  <= $signed({1'b0, e1_ff.sat}) - $signed({1'b0, e0_ff.sat});
            ss_ff  <= $signed({1'b0, s_ff}) - $signed({1'b0, e0_ff.sat});
            dvw_ff <= $signed({1'b0, e1_ff.wet}) - $signed({1'b0, e0_ff.wet});
            dvn_ff <= $signed({1'b0, e1_ff.nonwet}) - $signed({1'b0, e0_ff.nonwet});
            dvp_ff <= $signed({1'b0, e1_ff.press}) - $signed({1'b0, e0_ff.press});
         end
         ST_DEN: begin
            den_ff <= mul_p[33:0];
            op_ff  <= OP_WET_VAL;
         end
         ST_MUL: prod_ff <= mul_p;
         ST_DIVWAIT: begin
            if (div_done) begin
               res_ff[op_ff] <= post[47:0];
               if (op_ff != OP_PRESS_SLOPE) begin
                  op_ff <= op_type'(op_ff + 3'd1);
               end
            end
         end
         default: ;
      endcase
   end

   // Output register. End points override the segment results.
   logic s_zero, s_high, s_one;
   assign s_zero = (s_ff == 16'd0);
   assign s_high = s_ff[15];
   assign s_one  = (s_ff == ONE_Q15[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_bad_residuals <= bad;
         if (s_zero) begin
            rsp_wet_perm          <= 17'sd0;
            rsp_nonwet_perm       <= $signed(ONE_Q15);
            rsp_wet_perm_slope    <= 32'sd0;
            rsp_nonwet_perm_slope <= 32'sd0;
         end else if (s_high) begin
            rsp_wet_perm          <= $signed(ONE_Q15);
            rsp_nonwet_perm       <= 17'sd0;
            rsp_wet_perm_slope    <= 32'sd0;
            rsp_nonwet_perm_slope <= 32'sd0;
         end else begin
            rsp_wet_perm          <= res_ff[OP_WET_VAL][16:0];
            rsp_nonwet_perm       <= res_ff[OP_NONWET_VAL][16:0];
            rsp_wet_perm_slope    <= res_ff[OP_WET_SLOPE][31:0];
            rsp_nonwet_perm_slope <= res_ff[OP_NONWET_SLOPE][31:0];
         end
         if (s_zero) begin
            rsp_cap_pressure <= $signed({1'b0, max_pressure_ff});
         end else if (s_one) begin
            rsp_cap_pressure <= 33'sd0;
         end else begin
            rsp_cap_pressure <= res_ff[OP_PRESS_VAL][32:0];
         end
         if (s_zero || s_one) begin
            rsp_pressure_slope <= $signed(48'd0 - {16'd0, max_slope_ff});
         end else begin
            rsp_pressure_slope <= res_ff[OP_PRESS_SLOPE];
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/tci_table.sv
// Breakpoint table storage: one write port, one registered read port.
// Depends on tci_pkg for the entry layout.
module tci_table #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [4:0]                     wr_index,
   input  tci_pkg::entry_type             wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output tci_pkg::entry_type             rd_data
);
   import tci_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_index) < TABLE_DEPTH)) begin
         mem_ff[IDX_W'(wr_index)] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

### sv/tci_div.sv
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on tci_pkg only by convention; no shared types are needed.
module tci_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] numer,
   input  logic signed [33:0] denom,
   output logic               done,
   output logic signed [64:0] quot
);
   import tci_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  count_ff;
   logic        neg_ff;
   logic [33:0] dabs_ff;
   logic [34:0] rem_ff;
   logic [63:0] qt_ff;
   logic [34:0] shifted;
   logic [35:0] diff;

   assign shifted = {rem_ff[33:0], qt_ff[63]};
   assign diff    = {1'b0, shifted} - {2'b0, dabs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            count_ff <= 6'd63;
         end else if (busy_ff) begin
            if (count_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= numer[63] ^ denom[33];
         qt_ff   <= numer[63] ? 64'(-numer) : 64'(numer);
         dabs_ff <= denom[33] ? 34'(-denom) : 34'(denom);
         rem_ff  <= '0;
      end else if (busy_ff) begin
         if (!diff[35]) begin
            rem_ff <= diff[34:0];
            qt_ff  <= {qt_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            qt_ff  <= {qt_ff[62:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, qt_ff}) : $signed({1'b0, qt_ff});

endmodule

### sv/tci_checker.sv
// Port-level checks for the tabulated curve interpolator, bound to the top level.
// Depends only on the top level's ports.
module tci_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_type,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [16:0] rsp_wet_perm,
   input logic signed [31:0] rsp_wet_perm_slope,
   input logic               rsp_bad_residuals
);

   // A query item keeps the block busy for at least the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type) |=> !req_ready)
      else $error("ready stayed high after a query item");

   // A table write leaves the block ready.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_type) |=> req_ready)
      else $error("ready dropped after a write item");

   // A stalled result item stays valid and keeps its wet permeability.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_wet_perm)))
      else $error("stalled result item changed");

   // With bad residuals the wet permeability slope is flat or saturated.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_residuals) |->
         (rsp_wet_perm_slope == 32'sd0 || rsp_wet_perm_slope == 32'sh7fffffff ||
          rsp_wet_perm_slope == 32'sh80000000))
      else $error("slope not saturated under bad residuals");

endmodule

bind tabulated_curve_interpolator tci_checker u_tci_checker (.*);

### sim/tb_tabulated_curve_interpolator.sv
// Testbench for the tabulated curve interpolator: table writes, queries and CSR settings.
// Depends on tci_pkg and the tabulated_curve_interpolator RTL; self-checking, no files.
module tb_tabulated_curve_interpolator;
   timeunit 1ns;
   timeprecision 1ps;
   import tci_pkg::*;

   localparam int DEPTH       = 32;
   localparam int SETTLE_CYC  = 600;   // longer than the longest query takes
   localparam int HOLD_CYC    = 3000;  // long result back-pressure stretch

   // One input item as offered on the req channel.
   typedef struct {
      logic        kind;
      logic [4:0]  idx;
      logic [15:0] sat;
      logic [15:0] wet;
      logic [15:0] nonwet;
      logic [31:0] press;
   } curve_req_type;

   // One result item as seen on the rsp channel.
   typedef struct {
      logic signed [16:0] wet;
      logic signed [16:0] nonwet;
      logic signed [32:0] press;
      logic signed [31:0] wet_slope;
      logic signed [31:0] nonwet_slope;
      logic signed [47:0] press_slope;
      logic               bad;
   } curve_rsp_type;

   // The scoreboard keeps its own copy of the table and registers and predicts
   // the interpolated values for every accepted query.
   class curve_checker;
      logic [15:0] sat_tab[DEPTH];
      logic [15:0] wet_tab[DEPTH];
      logic [15:0] nonwet_tab[DEPTH];
      logic [31:0] press_tab[DEPTH];
      logic [5:0]  tab_len;
      logic [14:0] resid_water;
      logic [14:0] resid_oil;
      logic [31:0] max_press;
      logic [31:0] max_slope;
      curve_rsp_type expected_results[$];
      int          failures;
      int          mismatches;
      int          results_seen;

      function new();
         tab_len = 6'd2;
         resid_water = '0;
         resid_oil = '0;
         max_press = 32'd2560000000;
         max_slope = 32'd25600000;
         failures = 0;
         mismatches = 0;
         results_seen = 0;
         for (int i = 0; i < DEPTH; i++) begin
            sat_tab[i] = '0;
            wet_tab[i] = '0;
            nonwet_tab[i] = '0;
            press_tab[i] = '0;
         end
      endfunction

      function void set_reg(csr_idx_type idx, logic [31:0] v);
         case (idx)
            CSR_TABLE_LENGTH:   tab_len = v[5:0];
            CSR_RESIDUAL_WATER: resid_water = v[14:0];
            CSR_RESIDUAL_OIL:   resid_oil = v[14:0];
            CSR_MAX_PRESSURE:   max_press = v;
            CSR_MAX_SLOPE:      max_slope = v;
            default: ;
         endcase
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Linear interpolation, division truncated toward zero.
      function longint lerp(longint v0, longint v1, longint s, longint s0, longint s1);
         if (s1 == s0) return v0;
         return v0 + ((v1 - v0) * (s - s0)) / (s1 - s0);
      endfunction

      // Slope scaled by 1/(1-swr-snr); with bad residuals it pins to a rail.
      function longint seg_slope(longint dv, longint ds, longint unit, longint rem,
                                 bit bad, longint lo, longint hi);
         if (ds == 0 || dv == 0) return 0;
         if (bad) return ((dv < 0) != (ds < 0)) ? lo : hi;
         return clip((dv * unit) / (ds * rem), lo, hi);
      endfunction

      function void note_item(curve_req_type r);
         longint        s, rem, s0, s1, wp, nwp, pc, dwp, dnwp, dpc;
         bit            bad;
         int            len, seg;
         curve_rsp_type e;
         if (r.kind == REQ_WRITE) begin
            sat_tab[r.idx] = r.sat;
            wet_tab[r.idx] = r.wet;
            nonwet_tab[r.idx] = r.nonwet;
            press_tab[r.idx] = r.press;
            return;
         end
         s = r.sat;
         rem = 32768 - longint'(resid_water) - longint'(resid_oil);
         bad = (rem <= 0);
         len = tab_len;
         if (len < 2) len = 2;
         if (len > DEPTH) len = DEPTH;
         // First breakpoint above the query; running off the end keeps the last segment.
         seg = len - 1;
         for (int i = 1; i < len; i++) begin
            if (longint'(sat_tab[i]) > s) begin
               seg = i;
               break;
            end
         end
         s0 = sat_tab[seg-1];
         s1 = sat_tab[seg];
         if (s == 0) begin
            wp = 0; nwp = 32768; dwp = 0; dnwp = 0;
         end else if (s >= 32768) begin
            wp = 32768; nwp = 0; dwp = 0; dnwp = 0;
         end else begin
            wp = lerp(wet_tab[seg-1], wet_tab[seg], s, s0, s1);
            nwp = lerp(nonwet_tab[seg-1], nonwet_tab[seg], s, s0, s1);
            dwp = seg_slope(longint'(wet_tab[seg]) - longint'(wet_tab[seg-1]), s1 - s0,
                            64'sd1 <<< 31, rem, bad, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
            dnwp = seg_slope(longint'(nonwet_tab[seg]) - longint'(nonwet_tab[seg-1]),
                             s1 - s0, 64'sd1 <<< 31, rem, bad,
                             -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
         end
         // Pressure clamps only at exactly zero and exactly one.
         if (s == 0) begin
            pc = max_press;
            dpc = -longint'(max_slope);
         end else if (s == 32768) begin
            pc = 0;
            dpc = -longint'(max_slope);
         end else begin
            pc = lerp(press_tab[seg-1], press_tab[seg], s, s0, s1);
            dpc = seg_slope(longint'(press_tab[seg]) - longint'(press_tab[seg-1]), s1 - s0,
                            64'sd1 <<< 30, rem, bad, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
         end
         e.wet = 17'(clip(wp, -32768, 65535));
         e.nonwet = 17'(clip(nwp, -32768, 65535));
         e.press = 33'(clip(pc, -(64'sd1 <<< 31), (64'sd1 <<< 32) - 1));
         e.wet_slope = 32'(dwp);
         e.nonwet_slope = 32'(dnwp);
         e.press_slope = 48'(dpc);
         e.bad = bad;
         expected_results.insert(expected_results.size(), e);
      endfunction

      function void check_result(curve_rsp_type a);
         curve_rsp_type e;
         results_seen++;
         if (expected_results.size() == 0) begin
            failures++;
            $display("ERROR: result item with nothing expected");
            return;
         end
         e = expected_results.pop_front();
         if (a.wet !== e.wet || a.nonwet !== e.nonwet || a.press !== e.press ||
             a.wet_slope !== e.wet_slope || a.nonwet_slope !== e.nonwet_slope ||
             a.press_slope !== e.press_slope || a.bad !== e.bad) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) begin
               $display({"MISMATCH result %0d exp: kw=%0d kn=%0d pc=%0d ",
                         "dkw=%0d dkn=%0d dpc=%0d bad=%0d"},
                        results_seen, e.wet, e.nonwet, e.press, e.wet_slope,
                        e.nonwet_slope, e.press_slope, e.bad);
               $display({"MISMATCH result %0d act: kw=%0d kn=%0d pc=%0d ",
                         "dkw=%0d dkn=%0d dpc=%0d bad=%0d"},
                        results_seen, a.wet, a.nonwet, a.press, a.wet_slope,
                        a.nonwet_slope, a.press_slope, a.bad);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = REQ_WRITE;
   logic [4:0]         req_entry_index = '0;
   logic [15:0]        req_sat_point = '0;
   logic [15:0]        req_wet_perm_value = '0;
   logic [15:0]        req_nonwet_perm_value = '0;
   logic [31:0]        req_pressure_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [16:0] rsp_wet_perm;
   logic signed [16:0] rsp_nonwet_perm;
   logic signed [32:0] rsp_cap_pressure;
   logic signed [31:0] rsp_wet_perm_slope;
   logic signed [31:0] rsp_nonwet_perm_slope;
   logic signed [47:0] rsp_pressure_slope;
   logic               rsp_bad_residuals;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   curve_checker sb = new();
   // When set, neither side inserts idle cycles; some phases run this way.
   bit steady = 1'b0;

   tabulated_curve_interpolator #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(30_000_000);
      $display("simulation failed");
      $finish;
   end

   // Writes one register through a setup and an access cycle, then leaves the
   // bus idle. Only called while the block is idle, so the scoreboard copy
   // is updated right away.
   task automatic csr_write(csr_idx_type idx, logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   // Offers one item after a random gap and returns once it is accepted.
   // Valid stays high on exit so back-to-back items need no extra edge.
   task automatic offer_item(curve_req_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(13, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_entry_index <= r.idx;
      req_sat_point <= r.sat;
      req_wet_perm_value <= r.wet;
      req_nonwet_perm_value <= r.nonwet;
      req_pressure_value <= r.press;
      do @(posedge clock); while (!req_ready);
      sb.note_item(r);
   endtask

   task automatic write_entry(int idx, int sat, int wet, int nonwet, logic [31:0] press);
      curve_req_type r;
      r.kind = REQ_WRITE;
      r.idx = 5'(idx);
      r.sat = 16'(sat);
      r.wet = 16'(wet);
      r.nonwet = 16'(nonwet);
      r.press = press;
      offer_item(r);
   endtask

   // The entry_index and value fields of a query carry random noise; the block ignores them.
   task automatic query_at(int sat);
      curve_req_type r;
      r.kind = REQ_QUERY;
      r.idx = 5'($urandom);
      r.sat = 16'(sat);
      r.wet = 16'($urandom);
      r.nonwet = 16'($urandom);
      r.press = $urandom;
      offer_item(r);
   endtask

   // Lets the block drain completely before registers are touched.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Loads a monotonic table with random steps, some of them zero, so
   // that equal neighbouring breakpoints show up now and then.
   task automatic load_sorted_table();
      int cur;
      cur = 0;
      for (int i = 0; i < DEPTH; i++) begin
         write_entry(i, cur, $urandom_range(32768, 0), $urandom_range(32768, 0), $urandom);
         cur += ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(2200, 1);
         if (cur > 32768) cur = 32768;
      end
   endtask

   // Result side: random ready gaps, one long hold-off once enough results
   // have passed so that the block fills up and stalls its input.
   initial begin
      int  n;
      bit  held;
      curve_rsp_type a;
      held = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         n = steady ? 0 : $urandom_range(13, 0);
         if (!held && sb.results_seen >= 40) begin
            held = 1'b1;
            n = HOLD_CYC;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         a.wet = rsp_wet_perm;
         a.nonwet = rsp_nonwet_perm;
         a.press = rsp_cap_pressure;
         a.wet_slope = rsp_wet_perm_slope;
         a.nonwet_slope = rsp_nonwet_perm_slope;
         a.press_slope = rsp_pressure_slope;
         a.bad = rsp_bad_residuals;
         sb.check_result(a);
      end
   end

   initial begin
      int    tlen[8];
      int    rw[8];
      int    ro[8];
      int    qs;
      curve_req_type r;
      tlen = '{32, 2, 0, 63, 1, 33, 5, 12};
      // Residual pairs: none, both maximal, sum exactly one, remainder of one, and so on.
      rw = '{0, 32767, 16384, 3000, 0, 32767, 16384, 0};
      ro = '{0, 32767, 16384, 2000, 32767, 0, 16383, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset configuration (two breakpoints).
      write_entry(0, 0, 0, 32768, 32'hFFFF_FFFF);
      write_entry(1, 32768, 32768, 0, 32'h0);
      query_at(0);
      query_at(1);
      query_at(16384);
      query_at(32767);
      query_at(32768);
      query_at(32769);
      query_at(65535);
      // Descending saturations and extreme field values on the segment.
      write_entry(0, 65535, 65535, 0, 32'h0);
      write_entry(1, 100, 0, 65535, 32'hFFFF_FFFF);
      query_at(50);
      query_at(20000);
      // Equal breakpoint saturations give the left value and zero slopes.
      write_entry(0, 8000, 1234, 4321, 32'd777);
      write_entry(1, 8000, 30000, 100, 32'd99999);
      query_at(8000);
      query_at(4000);
      query_at(9000);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         steady = (p == 2 || p == 5);
         csr_write(CSR_TABLE_LENGTH, (p == 6) ? $urandom_range(32, 2) : tlen[p]);
         csr_write(CSR_RESIDUAL_WATER, (p == 7) ? $urandom_range(32767, 0) : rw[p]);
         csr_write(CSR_RESIDUAL_OIL, (p == 7) ? $urandom_range(32767, 0) : ro[p]);
         csr_write(CSR_MAX_PRESSURE, (p % 3 == 0) ? 32'h0 :
                                     (p % 3 == 1) ? 32'hFFFF_FFFF : $urandom);
         csr_write(CSR_MAX_SLOPE, (p % 3 == 1) ? 32'h0 :
                                  (p % 3 == 2) ? 32'hFFFF_FFFF : $urandom);
         load_sorted_table();
         for (int k = 0; k < 90; k++) begin
            if ($urandom_range(3, 0) == 0) begin
               // Random writes may leave the table unsorted, which the search must survive.
               r.kind = REQ_WRITE;
               r.idx = 5'($urandom);
               r.sat = ($urandom_range(4, 0) == 0) ? 16'($urandom) :
                                                    16'($urandom_range(32768, 0));
               r.wet = ($urandom_range(4, 0) == 0) ? 16'($urandom) :
                                                    16'($urandom_range(32768, 0));
               r.nonwet = ($urandom_range(4, 0) == 0) ? 16'($urandom) :
                                                       16'($urandom_range(32768, 0));
               r.press = $urandom;
               offer_item(r);
            end else begin
               case ($urandom_range(9, 0))
                  0: qs = 0;
                  1: qs = 32768;
                  2: qs = $urandom_range(65535, 32769);
                  3: qs = sb.sat_tab[$urandom_range(DEPTH - 1, 0)];
                  default: qs = $urandom_range(32767, 1);
               endcase
               query_at(qs);
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (sb.failures == 0 && sb.expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/tci_pkg.sv
sv/tci_table.sv
sv/tci_div.sv
sv/tabulated_curve_interpolator.sv
sv/tci_checker.sv
sim/tb_tabulated_curve_interpolator.sv
